### sv/linear_recurrence_mod_power_defines.svh
// assertion macros for the linear recurrence term block
`ifndef LINEAR_RECURRENCE_MOD_POWER_DEFINES_SVH
`define LINEAR_RECURRENCE_MOD_POWER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LRMP_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("lrmp assertion failed");

// next-cycle implication, disabled during reset
`define LRMP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("lrmp assertion failed");

`endif

### sv/lrmp_pkg.sv
// constants and types shared by the linear recurrence term block and its checker
`timescale 1ns / 1ps

package lrmp_pkg;

   localparam int RES_W       = 30;
   localparam int IDX_W       = 32;
   localparam int EXP_BITS    = 31;
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 32;

   localparam logic [RES_W-1:0] MODULUS = RES_W'(1000000007);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_ACCUM,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_ACC,
      PH_SQR,
      PH_FIN
   } phase_type;

endpackage

### sv/linear_recurrence_mod_power.sv
// Fibonacci-type term n modulo 1000000007 by 2x2 matrix power, bit-serial multiplier
//
//  channel  dir  fields (lowest bit up)
//  req      in   first_term[29:0], second_term[59:30], term_index[91:60], zero pad
//  rsp      out  term_value[29:0], zero pad
//
//  one request at a time; a modular multiply is a load, 30 serial steps and an accumulate
//  on the single shared shift-and-add unit; the exponent is the low 31 bits of n-1
//  req_tready is high only while idle; a finished term waits in the output register
//  a stalled rsp holds the block only at the end of the next request
//  synchronous reset clears the sequencer and the output valid, no clearing pass
`timescale 1ns / 1ps

module linear_recurrence_mod_power (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lrmp_pkg::REQ_TDATA_W-1:0] req_tdata,  // first_term, second_term, term_index
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lrmp_pkg::RSP_TDATA_W-1:0] rsp_tdata   // term_value
);
   import lrmp_pkg::*;

   localparam int BIT_W     = $clog2(RES_W);
   localparam int EXP_CNT_W = $clog2(EXP_BITS + 1);
   localparam int EXT_W     = (EXP_BITS > IDX_W) ? EXP_BITS : IDX_W;
   localparam logic [RES_W+1:0] MOD_X1 = {2'b00, MODULUS};
   localparam logic [RES_W+1:0] MOD_X2 = {1'b0, MODULUS, 1'b0};

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [1:0]           entry_ff, entry_in;
   logic                 term_ff, term_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [EXP_CNT_W-1:0] exp_cnt_ff, exp_cnt_in;
   logic [EXP_BITS-1:0]  e_ff, e_in;
   logic [RES_W-1:0]     f_ff [0:1];
   logic [RES_W-1:0]     f_in [0:1];
   logic [RES_W-1:0]     acc_ff [0:3];
   logic [RES_W-1:0]     acc_in [0:3];
   logic [RES_W-1:0]     sq_ff [0:3];
   logic [RES_W-1:0]     sq_in [0:3];
   logic [RES_W-1:0]     tmp_ff [0:3];
   logic [RES_W-1:0]     tmp_in [0:3];
   logic [RES_W-1:0]     mul_a_ff, mul_a_in;
   logic [RES_W-1:0]     mul_b_ff, mul_b_in;
   logic [RES_W-1:0]     r_ff, r_in;
   logic [RES_W-1:0]     sum_ff, sum_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RES_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   logic [RES_W-1:0]     first_term, second_term;
   logic [IDX_W-1:0]     term_index, n_minus;
   logic [EXT_W-1:0]     n_ext;
   logic [EXP_BITS-1:0]  e_new;
   logic [RES_W-1:0]     x_sel, y_sel;
   logic [RES_W+1:0]     step_t, step_t1, step_t2;
   logic [RES_W-1:0]     step_r;
   logic [RES_W:0]       add_s, add_d;
   logic [RES_W-1:0]     add_r;
   logic [EXP_BITS-1:0]  e_shift;

   assign first_term  = req_tdata[RES_W-1:0];
   assign second_term = req_tdata[2*RES_W-1:RES_W];
   assign term_index  = req_tdata[2*RES_W+IDX_W-1:2*RES_W];
   assign n_minus     = term_index - IDX_W'(1);
   assign n_ext       = EXT_W'(n_minus);
   assign e_new       = n_ext[EXP_BITS-1:0];
   assign e_shift     = e_ff >> 1;

   // operand selection for the current product
   always_comb begin
      case (phase_ff)
         PH_ACC: begin
            x_sel = acc_ff[{entry_ff[1], term_ff}];
            y_sel = sq_ff[{term_ff, entry_ff[0]}];
         end
         PH_SQR: begin
            x_sel = sq_ff[{entry_ff[1], term_ff}];
            y_sel = sq_ff[{term_ff, entry_ff[0]}];
         end
         PH_FIN: begin
            x_sel = f_ff[term_ff];
            y_sel = acc_ff[{term_ff, 1'b0}];
         end
         default: begin
            x_sel = '0;
            y_sel = '0;
         end
      endcase
   end

   // one interleaved multiply step: r = 2r + b_bit*a mod p
   always_comb begin
      step_t  = {1'b0, r_ff, 1'b0} + (mul_b_ff[RES_W-1] ? {2'b00, mul_a_ff} : '0);
      step_t1 = step_t - MOD_X1;
      step_t2 = step_t - MOD_X2;
      if (step_t >= MOD_X2) begin
         step_r = step_t2[RES_W-1:0];
      end else if (step_t >= MOD_X1) begin
         step_r = step_t1[RES_W-1:0];
      end else begin
         step_r = step_t[RES_W-1:0];
      end
   end

   // modular add of the pending partial sum and the finished product
   always_comb begin
      add_s = {1'b0, sum_ff} + {1'b0, r_ff};
      add_d = add_s - {1'b0, MODULUS};
      add_r = (add_s >= {1'b0, MODULUS}) ? add_d[RES_W-1:0] : add_s[RES_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      entry_in      = entry_ff;
      term_in       = term_ff;
      bit_in        = bit_ff;
      exp_cnt_in    = exp_cnt_ff;
      e_in          = e_ff;
      f_in          = f_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      tmp_in        = tmp_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      r_in          = r_ff;
      sum_in        = sum_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               f_in[0]    = (first_term >= MODULUS) ? first_term - MODULUS : first_term;
               f_in[1]    = (second_term >= MODULUS) ? second_term - MODULUS : second_term;
               e_in       = e_new;
               exp_cnt_in = '0;
               acc_in[0]  = RES_W'(1);
               acc_in[1]  = '0;
               acc_in[2]  = '0;
               acc_in[3]  = RES_W'(1);
               sq_in[0]   = '0;
               sq_in[1]   = RES_W'(1);
               sq_in[2]   = RES_W'(1);
               sq_in[3]   = RES_W'(1);
               phase_in   = e_new[0] ? PH_ACC : PH_SQR;
               entry_in   = '0;
               term_in    = 1'b0;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mul_a_in = x_sel;
            mul_b_in = y_sel;
            r_in     = '0;
            bit_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            r_in     = step_r;
            mul_b_in = mul_b_ff << 1;
            bit_in   = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(RES_W - 1)) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (!term_ff) begin
               sum_in   = r_ff;
               term_in  = 1'b1;
               state_in = ST_LOAD;
            end else begin
               tmp_in[entry_ff] = add_r;
               term_in          = 1'b0;
               state_in         = ST_LOAD;
               if (phase_ff == PH_FIN) begin
                  state_in = ST_OUT;
               end else if (entry_ff == 2'd3) begin
                  entry_in = '0;
                  if (phase_ff == PH_ACC) begin
                     acc_in   = tmp_in;
                     phase_in = PH_SQR;
                  end else begin
                     sq_in      = tmp_in;
                     e_in       = e_shift;
                     exp_cnt_in = exp_cnt_ff + EXP_CNT_W'(1);
                     if (exp_cnt_ff == EXP_CNT_W'(EXP_BITS - 1)) begin
                        phase_in = PH_FIN;
                     end else begin
                        phase_in = e_shift[0] ? PH_ACC : PH_SQR;
                     end
                  end
               end else begin
                  entry_in = entry_ff + 2'd1;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = tmp_ff[0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      entry_ff     <= entry_in;
      term_ff      <= term_in;
      bit_ff       <= bit_in;
      exp_cnt_ff   <= exp_cnt_in;
      e_ff         <= e_in;
      f_ff         <= f_in;
      acc_ff       <= acc_in;
      sq_ff        <= sq_in;
      tmp_ff       <= tmp_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      r_ff         <= r_in;
      sum_ff       <= sum_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RES_W)'(0), rsp_tdata_ff};

endmodule

### sv/lrmp_checker.sv
// port-level checks for the linear recurrence term block, bound to the top level
`timescale 1ns / 1ps
`include "linear_recurrence_mod_power_defines.svh"

module lrmp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [lrmp_pkg::REQ_TDATA_W-1:0] req_tdata,  // first_term, second_term, term_index
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lrmp_pkg::RSP_TDATA_W-1:0] rsp_tdata   // term_value
);
   import lrmp_pkg::*;

   logic req_fire;
   logic rsp_stall;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // term value is a reduced residue with zero padding
   `LRMP_ASSERT_IMPLY(a_rsp_reduced, clock, reset, rsp_tvalid, rsp_tdata[RES_W-1:0] < MODULUS)
   `LRMP_ASSERT_IMPLY(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[RSP_TDATA_W-1:RES_W] == '0)
   // block is busy right after taking a request
   `LRMP_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_tready)
   // stalled response holds
   `LRMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind linear_recurrence_mod_power lrmp_checker u_lrmp_checker (.*);
